[rtl/core/bm25s_pkg.sv]
// Shared constants and formats of the BM25 relevance scorer.
package bm25s_pkg;

    // Default count width of the document counters
    localparam int DEF_COUNT_BITS = 32;

    // Field widths
    localparam int LEN_W   = 24;
    localparam int AVG_W   = 32;
    localparam int SCORE_W = 32;
    localparam int K1_W    = 16;
    localparam int B_W     = 17;
    localparam int FLOOR_W = 16;

    // Configuration port
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 17;
    typedef logic [CFG_IDX_W-1:0] t_cfg_idx;
    localparam t_cfg_idx CFG_K1_GAIN       = 2'd0;
    localparam t_cfg_idx CFG_B_LENGTH_NORM = 2'd1;
    localparam t_cfg_idx CFG_IDF_FLOOR     = 2'd2;

    // Register reset values and fixed-point unit constants
    localparam logic [K1_W-1:0]    K1_RESET    = 16'd4915;
    localparam logic [B_W-1:0]     B_RESET     = 17'd49152;
    localparam logic [FLOOR_W-1:0] FLOOR_RESET = 16'd16384;
    localparam logic [B_W-1:0]     B_ONE       = 17'd65536;
    localparam logic [B_W-1:0]     K1_ONE      = 17'd4096;

    // Logarithm unit: Q1.30 mantissa, 28 fraction bits by repeated squaring
    localparam int MANT_W    = 31;
    localparam int FRAC_BITS = 28;
    localparam int LN_LAT    = 2 + FRAC_BITS + 1;
    localparam logic [29:0] LN2_Q30  = 30'd744261118;
    localparam logic [29:0] HALF_Q30 = 30'd536870912;

    // Divider quotient widths
    localparam int NL_QBITS = 48;
    localparam int DW_QBITS = 25;

    // Term weight waits for the length ratio divider
    localparam int TW_DELAY = NL_QBITS - LN_LAT - 2;

endpackage

[rtl/core/bm25s_ln_pipe.sv]
// Pipelined natural logarithm in Q.28 of an integer x >= 1.
module bm25s_ln_pipe #(
    parameter int XW = 33
) (
    input  logic                                          i_clk,
    input  logic                                          i_en,
    input  logic [XW-1:0]                                 i_x,
    output logic [$clog2(XW)+bm25s_pkg::FRAC_BITS-1:0]    o_ln
);
    import bm25s_pkg::*;

    localparam int EW  = $clog2(XW);
    localparam int LNW = EW + FRAC_BITS;
    localparam int NW  = XW + MANT_W;
    localparam int PW  = LNW + 30;

    logic [XW-1:0]        r_xa;
    logic [EW-1:0]        r_ea;
    logic [EW-1:0]        n_ea;
    logic [NW-1:0]        shifted;
    logic [MANT_W-1:0]    r_m [0:FRAC_BITS];
    logic [FRAC_BITS-1:0] r_f [0:FRAC_BITS];
    logic [EW-1:0]        r_e [0:FRAC_BITS];
    logic [LNW-1:0]       lg;
    logic [PW-1:0]        prod;
    logic [LNW-1:0]       r_ln;

    // Stage A: position of the leading one
    always_comb begin
        n_ea = '0;
        for (int i = 0; i < XW; i++) begin
            if (i_x[i]) begin
                n_ea = EW'(i);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_xa <= i_x;
            r_ea <= n_ea;
        end
    end

    // Stage B: normalize to a Q1.30 mantissa, low bits truncated
    assign shifted = {r_xa, MANT_W'(0)} << (EW'(XW - 1) - r_ea);

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_m[0] <= shifted[NW-1 -: MANT_W];
            r_f[0] <= '0;
            r_e[0] <= r_ea;
        end
    end

    // Squaring stages: one fraction bit of log2 each
    for (genvar k = 0; k < FRAC_BITS; k++) begin : g_sq
        logic [2*MANT_W-1:0] sq;
        logic [MANT_W:0]     t;

        assign sq = {{MANT_W{1'b0}}, r_m[k]} * {{MANT_W{1'b0}}, r_m[k]};
        assign t  = sq[2*MANT_W-1 : MANT_W-1];

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_m[k+1] <= t[MANT_W] ? t[MANT_W:1] : t[MANT_W-1:0];
                r_f[k+1] <= {r_f[k][FRAC_BITS-2:0], t[MANT_W]};
                r_e[k+1] <= r_e[k];
            end
        end
    end

    // Final stage: log2 times ln2, rounded
    assign lg   = {r_e[FRAC_BITS], r_f[FRAC_BITS]};
    assign prod = PW'(lg) * PW'(LN2_Q30) + PW'(HALF_Q30);

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_ln <= prod[PW-1:30];
        end
    end

    assign o_ln = r_ln;

endmodule

[rtl/core/bm25s_div_pipe.sv]
// Pipelined restoring divider, one quotient bit per stage, with sideband.
module bm25s_div_pipe #(
    parameter int NUM_W  = 49,
    parameter int DEN_W  = 32,
    parameter int Q_BITS = 48,
    parameter int SIDE_W = 1
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_en,
    input  logic              i_valid,
    input  logic [NUM_W-1:0]  i_num,
    input  logic [DEN_W-1:0]  i_den,
    input  logic [SIDE_W-1:0] i_side,
    output logic              o_valid,
    output logic [Q_BITS-1:0] o_quo,
    output logic [SIDE_W-1:0] o_side
);
    import bm25s_pkg::*;

    logic              r_valid [0:Q_BITS-1];
    logic [DEN_W-1:0]  r_rem   [0:Q_BITS-1];
    logic [NUM_W-1:0]  r_num   [0:Q_BITS-1];
    logic [DEN_W-1:0]  r_den   [0:Q_BITS-1];
    logic [Q_BITS-1:0] r_quo   [0:Q_BITS-1];
    logic [SIDE_W-1:0] r_side  [0:Q_BITS-1];

    for (genvar k = 0; k < Q_BITS; k++) begin : g_stage
        logic              s_valid;
        logic [DEN_W-1:0]  s_rem;
        logic [NUM_W-1:0]  s_num;
        logic [DEN_W-1:0]  s_den;
        logic [Q_BITS-1:0] s_quo;
        logic [SIDE_W-1:0] s_side;
        logic [DEN_W:0]    r2;
        logic [DEN_W:0]    diff;
        logic              ge;

        // Stage inputs: the ports for the first stage, else the previous stage
        if (k == 0) begin : g_first
            assign s_valid = i_valid;
            assign s_rem   = DEN_W'(i_num[NUM_W-1:Q_BITS]);
            assign s_num   = i_num;
            assign s_den   = i_den;
            assign s_quo   = '0;
            assign s_side  = i_side;
        end else begin : g_next
            assign s_valid = r_valid[k-1];
            assign s_rem   = r_rem[k-1];
            assign s_num   = r_num[k-1];
            assign s_den   = r_den[k-1];
            assign s_quo   = r_quo[k-1];
            assign s_side  = r_side[k-1];
        end

        // Shift in the next dividend bit, subtract when it fits
        assign r2   = {s_rem, s_num[Q_BITS-1-k]};
        assign ge   = (r2 >= {1'b0, s_den});
        assign diff = r2 - {1'b0, s_den};

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_valid[k] <= 1'b0;
            end else if (i_en) begin
                r_valid[k] <= s_valid;
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_rem[k]  <= ge ? diff[DEN_W-1:0] : r2[DEN_W-1:0];
                r_num[k]  <= s_num;
                r_den[k]  <= s_den;
                r_quo[k]  <= {s_quo[Q_BITS-2:0], ge};
                r_side[k] <= s_side;
            end
        end
    end

    assign o_valid = r_valid[Q_BITS-1];
    assign o_quo   = r_quo[Q_BITS-1];
    assign o_side  = r_side[Q_BITS-1];

endmodule

[rtl/core/bm25_relevance_scorer_unit.sv]
// Top level of the BM25 relevance scorer: one term-document pair per item.
//
//  channel  | direction | handshake                  | payload
//  ---------+-----------+----------------------------+------------------------------------
//  input    | in        | i_valid / o_stall          | df, N, length, tf, average length
//  output   | out       | o_valid / i_stall          | o_relevance (Q16.16), o_status
//  config   | in        | i_cfg_valid / o_cfg_ready  | i_cfg_index, i_cfg_data
//
// One item enters per cycle while o_stall is low; the path holds the two bit-serial
// divider pipelines (length ratio and document weight).
// The logarithm units (31 stages) run beside the length ratio divider.
// Reset clears the valid bits and loads the register defaults; config is always ready.
// A stalled, full output register freezes the whole pipeline, bubbles included.
module bm25_relevance_scorer_unit #(
    parameter int COUNT_BITS = bm25s_pkg::DEF_COUNT_BITS
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_valid,
    output logic                             o_stall,
    input  logic [COUNT_BITS-1:0]            i_term_doc_count,
    input  logic [COUNT_BITS-1:0]            i_total_docs,
    input  logic [bm25s_pkg::LEN_W-1:0]      i_doc_length,
    input  logic [bm25s_pkg::LEN_W-1:0]      i_term_freq,
    input  logic [bm25s_pkg::AVG_W-1:0]      i_avg_doc_length,
    output logic                             o_valid,
    input  logic                             i_stall,
    output logic [bm25s_pkg::SCORE_W-1:0]    o_relevance,
    output logic                             o_status,
    input  logic                             i_cfg_valid,
    output logic                             o_cfg_ready,
    input  logic [bm25s_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [bm25s_pkg::CFG_DATA_W-1:0] i_cfg_data
);
    import bm25s_pkg::*;

    localparam int XW    = COUNT_BITS + 1;
    localparam int LNW   = $clog2(XW) + FRAC_BITS;
    localparam int TWW   = LNW - 7;
    localparam int NL_NW = 1 + LEN_W + 24;
    localparam int TF12W = LEN_W + 12;
    localparam int DENW  = 51;
    localparam int DW_NW = TF12W + 24;
    localparam int PRW   = TWW + DW_QBITS;
    localparam int IW    = 66;

    logic en;

    // Configuration registers
    logic [K1_W-1:0]    r_k1_gain;
    logic [B_W-1:0]     r_b_length_norm;
    logic [FLOOR_W-1:0] r_idf_floor;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_k1_gain       <= K1_RESET;
            r_b_length_norm <= B_RESET;
            r_idf_floor     <= FLOOR_RESET;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                CFG_K1_GAIN:       r_k1_gain       <= i_cfg_data[K1_W-1:0];
                CFG_B_LENGTH_NORM: r_b_length_norm <= i_cfg_data;
                CFG_IDF_FLOOR:     r_idf_floor     <= i_cfg_data[FLOOR_W-1:0];
                default: ;
            endcase
        end
    end

    // Pipeline advances unless a held result is stalled
    assign en      = !(o_valid && i_stall);
    assign o_stall = !en;

    // Stage 0: capture the item, form 2d+1 and 2df+1
    logic                  r0_valid;
    logic [XW-1:0]         r0_xn;
    logic [XW-1:0]         r0_xd;
    logic [LEN_W-1:0]      r0_len;
    logic [LEN_W-1:0]      r0_tf;
    logic [AVG_W-1:0]      r0_avg;
    logic [COUNT_BITS-1:0] n_d;

    assign n_d = (i_total_docs > i_term_doc_count) ?
                 (i_total_docs - i_term_doc_count) : '0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r0_valid <= 1'b0;
        end else if (en) begin
            r0_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r0_xn  <= {n_d, 1'b1};
            r0_xd  <= {i_term_doc_count, 1'b1};
            r0_len <= i_doc_length;
            r0_tf  <= i_term_freq;
            r0_avg <= i_avg_doc_length;
        end
    end

    // Logarithms of numerator and denominator
    logic [LNW-1:0] ln_num;
    logic [LNW-1:0] ln_den;

    bm25s_ln_pipe #(.XW(XW)) u_ln_num (
        .i_clk (i_clk),
        .i_en  (en),
        .i_x   (r0_xn),
        .o_ln  (ln_num)
    );

    bm25s_ln_pipe #(.XW(XW)) u_ln_den (
        .i_clk (i_clk),
        .i_en  (en),
        .i_x   (r0_xd),
        .o_ln  (ln_den)
    );

    // idf: clamp at zero, then at the floor
    logic [LNW-1:0] r_idf;
    logic [LNW-1:0] idf_pos;
    logic [LNW-1:0] floor_q28;
    logic [LNW+16:0] tw_prod;
    logic [TWW-1:0] r_tw;

    assign idf_pos   = (ln_num > ln_den) ? (ln_num - ln_den) : '0;
    assign floor_q28 = LNW'({r_idf_floor, 12'b0});

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_idf <= (idf_pos < floor_q28) ? floor_q28 : idf_pos;
        end
    end

    // Term weight: idf times (1 + k1)
    assign tw_prod = (LNW+17)'(r_idf) * (LNW+17)'(K1_ONE + B_W'(r_k1_gain));

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_tw <= tw_prod[LNW+16:24];
        end
    end

    // Term weight delay line, aligned with the length ratio divider
    logic [TWW-1:0] r_tw_dly [0:TW_DELAY-1];

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_tw_dly[0] <= r_tw;
            for (int i = 1; i < TW_DELAY; i++) begin
                r_tw_dly[i] <= r_tw_dly[i-1];
            end
        end
    end

    // Length ratio nl = (len << 24) / avg
    logic                 d1_valid;
    logic [NL_QBITS-1:0]  d1_nl;
    logic [LEN_W:0]       d1_side;

    bm25s_div_pipe #(
        .NUM_W  (NL_NW),
        .DEN_W  (AVG_W),
        .Q_BITS (NL_QBITS),
        .SIDE_W (LEN_W + 1)
    ) u_div_nl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (r0_valid),
        .i_num   ({1'b0, r0_len, 24'b0}),
        .i_den   (r0_avg),
        .i_side  ({r0_tf, (r0_avg == '0)}),
        .o_valid (d1_valid),
        .o_quo   (d1_nl),
        .o_side  (d1_side)
    );

    // P1: b times nl in two partial products
    logic [B_W-1:0]   b_sat;
    logic             r1_valid;
    logic [B_W+23:0]  r1_pl;
    logic [B_W+23:0]  r1_ph;
    logic [B_W-1:0]   r1_omb;
    logic [LEN_W-1:0] r1_tf;
    logic             r1_zavg;
    logic [TWW-1:0]   r1_tw;

    assign b_sat = (r_b_length_norm > B_ONE) ? B_ONE : r_b_length_norm;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_valid <= 1'b0;
        end else if (en) begin
            r1_valid <= d1_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r1_pl   <= (B_W+24)'(b_sat) * (B_W+24)'(d1_nl[23:0]);
            r1_ph   <= (B_W+24)'(b_sat) * (B_W+24)'(d1_nl[47:24]);
            r1_omb  <= B_ONE - b_sat;
            r1_tf   <= d1_side[LEN_W:1];
            r1_zavg <= d1_side[0];
            r1_tw   <= r_tw_dly[TW_DELAY-1];
        end
    end

    // P2: inner length factor in Q.32, kept in Q.16
    logic [IW-1:0]    inner;
    logic             r2_valid;
    logic [49:0]      r2_ih;
    logic [LEN_W-1:0] r2_tf;
    logic             r2_zavg;
    logic [TWW-1:0]   r2_tw;

    assign inner = (IW'(r1_omb) << 16) + IW'(r1_pl) + (IW'(r1_ph) << 24);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r2_valid <= 1'b0;
        end else if (en) begin
            r2_valid <= r1_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r2_ih   <= inner[IW-1:16];
            r2_tf   <= r1_tf;
            r2_zavg <= r1_zavg;
            r2_tw   <= r1_tw;
        end
    end

    // P3: times k1 in two partial products
    logic             r3_valid;
    logic [40:0]      r3_kl;
    logic [40:0]      r3_kh;
    logic [LEN_W-1:0] r3_tf;
    logic             r3_zavg;
    logic [TWW-1:0]   r3_tw;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r3_valid <= 1'b0;
        end else if (en) begin
            r3_valid <= r2_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r3_kl   <= 41'(r2_ih[24:0]) * 41'(r_k1_gain);
            r3_kh   <= 41'(r2_ih[49:25]) * 41'(r_k1_gain);
            r3_tf   <= r2_tf;
            r3_zavg <= r2_zavg;
            r3_tw   <= r2_tw;
        end
    end

    // P4: length factor L in Q.12 and denominator tf*4096 + L
    logic [IW-1:0]    lsum;
    logic [DENW-1:0]  den;
    logic             r4_valid;
    logic [DENW-1:0]  r4_den;
    logic [TF12W-1:0] r4_tf12;
    logic             r4_flag;
    logic [TWW-1:0]   r4_tw;

    assign lsum = IW'(r3_kl) + (IW'(r3_kh) << 25);
    assign den  = DENW'({r3_tf, 12'b0}) + DENW'(lsum[IW-1:16]);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r4_valid <= 1'b0;
        end else if (en) begin
            r4_valid <= r3_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r4_den  <= den;
            r4_tf12 <= {r3_tf, 12'b0};
            r4_flag <= r3_zavg || (den == '0);
            r4_tw   <= r3_tw;
        end
    end

    // Document weight dw = (tf12 << 24) / den, in Q.24
    logic                d2_valid;
    logic [DW_QBITS-1:0] d2_dw;
    logic [TWW:0]        d2_side;

    bm25s_div_pipe #(
        .NUM_W  (DW_NW),
        .DEN_W  (DENW),
        .Q_BITS (DW_QBITS),
        .SIDE_W (TWW + 1)
    ) u_div_dw (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (r4_valid),
        .i_num   ({r4_tf12, 24'b0}),
        .i_den   (r4_den),
        .i_side  ({r4_tw, r4_flag}),
        .o_valid (d2_valid),
        .o_quo   (d2_dw),
        .o_side  (d2_side)
    );

    // F1: score product
    logic           r_prod_valid;
    logic [PRW-1:0] r_prod;
    logic           r_flag;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prod_valid <= 1'b0;
        end else if (en) begin
            r_prod_valid <= d2_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_prod <= PRW'(d2_side[TWW:1]) * PRW'(d2_dw);
            r_flag <= d2_side[0];
        end
    end

    // Output register: shift, saturate, force zero on a zero divisor
    logic [63:0]         sc64;
    logic [SCORE_W-1:0]  sat_score;
    logic                r_out_valid;
    logic [SCORE_W-1:0]  r_relevance;
    logic                r_status;

    assign sc64      = 64'(r_prod >> 24);
    assign sat_score = (|sc64[63:SCORE_W]) ? '1 : sc64[SCORE_W-1:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (en) begin
            r_out_valid <= r_prod_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_relevance <= r_flag ? '0 : sat_score;
            r_status    <= r_flag;
        end
    end

    assign o_valid     = r_out_valid;
    assign o_relevance = r_relevance;
    assign o_status    = r_status;

endmodule

[test/tb_bm25_relevance_scorer_unit.sv]
// Self-checking testbench of the BM25 relevance scorer: directed table, then random pairs.
module tb_bm25_relevance_scorer_unit;
    timeunit 1ns;
    timeprecision 1ps;
    import bm25s_pkg::*;

    localparam int CNT_W     = DEF_COUNT_BITS;
    localparam int DRAIN_CYC = 100;
    localparam int WD_LIMIT  = 3000;
    localparam int LONG_HOLD = 300;
    localparam int MAX_SHOWN = 10;

    typedef struct {
        logic [CNT_W-1:0] df;
        logic [CNT_W-1:0] n;
        logic [LEN_W-1:0] len;
        logic [LEN_W-1:0] tf;
        logic [AVG_W-1:0] avg;
        bit               fixed;
        logic [SCORE_W-1:0] fix_rel;
        logic             fix_st;
    } t_pair;

    typedef struct {
        logic [SCORE_W-1:0] rel;
        logic               st;
    } t_score;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n = 1'b0;
    logic                  i_valid = 1'b0;
    logic                  o_stall;
    logic [CNT_W-1:0]      i_term_doc_count = '0;
    logic [CNT_W-1:0]      i_total_docs = '0;
    logic [LEN_W-1:0]      i_doc_length = '0;
    logic [LEN_W-1:0]      i_term_freq = '0;
    logic [AVG_W-1:0]      i_avg_doc_length = '0;
    logic                  o_valid;
    logic                  i_stall = 1'b0;
    logic [SCORE_W-1:0]    o_relevance;
    logic                  o_status;
    logic                  i_cfg_valid = 1'b0;
    logic                  o_cfg_ready;
    logic [CFG_IDX_W-1:0]  i_cfg_index = '0;
    logic [CFG_DATA_W-1:0] i_cfg_data = '0;

    // Side info that travels with the driven item
    bit                    cur_fixed = 0;
    logic [SCORE_W-1:0]    cur_fix_rel = '0;
    logic                  cur_fix_st = 1'b0;

    bm25_relevance_scorer_unit #(.COUNT_BITS(CNT_W)) dut (.*);

    always #10 i_clk = ~i_clk;

    // Shadow registers
    logic [K1_W-1:0]    k1_sh = K1_RESET;
    logic [B_W-1:0]     b_sh = B_RESET;
    logic [FLOOR_W-1:0] floor_sh = FLOOR_RESET;

    t_score pending_scores[$];
    int     mismatches = 0;
    int     wd_count = 0;
    bit     hold_long = 0;
    bit     quiet = 0;

    // Natural log in Q.28 of an integer >= 1
    function automatic logic [63:0] nat_log_q28(input logic [63:0] x);
        logic [63:0] e, m, frac;
        int i;
        e = 0;
        frac = 0;
        if (x == 0) return 0;
        while (e < 63 && (x >> (e + 1)) != 0) e++;
        m = (e <= 30) ? (x << (30 - e)) : (x >> (e - 30));
        for (i = 0; i < FRAC_BITS; i++) begin
            m = (m * m) >> 30;
            frac = frac << 1;
            if (m >= 64'h8000_0000) begin
                m = m >> 1;
                frac = frac | 64'd1;
            end
        end
        return (((e << 28) | frac) * 64'(LN2_Q30) + (64'd1 << 29)) >> 30;
    endfunction

    // Expected BM25 score of one pair under the shadow registers
    function automatic t_score bm25_expect(input t_pair p);
        t_score r;
        logic [63:0] df, n, d, lnum, lden, idf, fl, tw, nl, inner, lfac, tf12, den, dw, sc, b;
        df = 64'(p.df);
        n = 64'(p.n);
        b = (b_sh > B_ONE) ? 64'(B_ONE) : 64'(b_sh);
        r.rel = '0;
        r.st = 1'b1;
        if (p.avg == 0) return r;
        d = (n > df) ? n - df : 0;
        lnum = nat_log_q28(2 * d + 1);
        lden = nat_log_q28(2 * df + 1);
        idf = (lnum > lden) ? lnum - lden : 0;
        fl = 64'(floor_sh) << 12;
        if (idf < fl) idf = fl;
        tw = (idf * (64'd4096 + 64'(k1_sh))) >> 24;
        nl = (64'(p.len) << 24) / 64'(p.avg);
        inner = ((64'd65536 - b) << 16) + b * nl;
        lfac = ((inner >> 16) * 64'(k1_sh)) >> 16;
        tf12 = 64'(p.tf) << 12;
        den = tf12 + lfac;
        if (den == 0) return r;
        dw = (tf12 << 24) / den;
        sc = (tw * dw) >> 24;
        r.rel = (sc > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : sc[31:0];
        r.st = 1'b0;
        return r;
    endfunction

    // Input acceptance: record the expected score
    always @(posedge i_clk) begin
        t_pair p;
        t_score s;
        if (i_rst_n && i_valid && !o_stall) begin
            p.df = i_term_doc_count;
            p.n = i_total_docs;
            p.len = i_doc_length;
            p.tf = i_term_freq;
            p.avg = i_avg_doc_length;
            if (cur_fixed) begin
                s.rel = cur_fix_rel;
                s.st = cur_fix_st;
            end else begin
                s = bm25_expect(p);
            end
            pending_scores.push_back(s);
        end
    end

    // Config acceptance: update shadow registers
    always @(posedge i_clk) begin
        if (i_rst_n && i_cfg_valid && o_cfg_ready) begin
            case (i_cfg_index)
                CFG_K1_GAIN:       k1_sh <= i_cfg_data[K1_W-1:0];
                CFG_B_LENGTH_NORM: b_sh <= i_cfg_data[B_W-1:0];
                CFG_IDF_FLOOR:     floor_sh <= i_cfg_data[FLOOR_W-1:0];
                default: ;
            endcase
        end
    end

    // Output check against the oldest expected score
    always @(posedge i_clk) begin
        t_score s;
        if (i_rst_n && o_valid && !i_stall) begin
            if (pending_scores.size() == 0) begin
                mismatches++;
                if (mismatches <= MAX_SHOWN)
                    $display("unexpected result rel=%h st=%b", o_relevance, o_status);
            end else begin
                s = pending_scores.pop_front();
                if (s.rel !== o_relevance || s.st !== o_status) begin
                    mismatches++;
                    if (mismatches <= MAX_SHOWN)
                        $display("mismatch: exp rel=%h st=%b got rel=%h st=%b",
                                 s.rel, s.st, o_relevance, o_status);
                end
            end
        end
    end

    // Watchdog on cycles without any handshake
    always @(posedge i_clk) begin
        if ((i_valid && !o_stall) || (o_valid && !i_stall) || (i_cfg_valid && o_cfg_ready))
            wd_count <= 0;
        else
            wd_count <= wd_count + 1;
        if (wd_count >= WD_LIMIT) begin
            $display("Test completed with failures");
            $finish;
        end
    end

    // Receiver: random back-pressure per item, one long hold on request
    initial begin
        int w;
        @(posedge i_rst_n);
        @(negedge i_clk);
        forever begin
            if (hold_long) begin
                i_stall <= 1'b1;
                repeat (LONG_HOLD) @(negedge i_clk);
                hold_long = 0;
            end else begin
                w = quiet ? 0 : $urandom_range(0, 4);
                if (w > 0) begin
                    i_stall <= 1'b1;
                    repeat (w) @(negedge i_clk);
                end
            end
            i_stall <= 1'b0;
            @(posedge i_clk);
            while (!o_valid) @(posedge i_clk);
            @(negedge i_clk);
        end
    end

    // Drive one pair, honoring a random gap; called at a falling edge
    task automatic send_pair(input t_pair p);
        int gap;
        gap = quiet ? 0 : $urandom_range(0, 4);
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_valid <= 1'b1;
        i_term_doc_count <= p.df;
        i_total_docs <= p.n;
        i_doc_length <= p.len;
        i_term_freq <= p.tf;
        i_avg_doc_length <= p.avg;
        cur_fixed <= p.fixed;
        cur_fix_rel <= p.fix_rel;
        cur_fix_st <= p.fix_st;
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    task automatic cfg_write(input t_cfg_idx idx, input logic [CFG_DATA_W-1:0] val);
        @(negedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= val;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    // Wait until every expected score has come, then let the pipe settle
    task automatic drain_pipe();
        i_valid <= 1'b0;
        while (pending_scores.size() != 0) @(negedge i_clk);
        repeat (DRAIN_CYC) @(negedge i_clk);
    endtask

    task automatic set_regs(input logic [K1_W-1:0] k1, input logic [B_W-1:0] b,
                            input logic [FLOOR_W-1:0] fl);
        cfg_write(CFG_K1_GAIN, CFG_DATA_W'(k1));
        cfg_write(CFG_B_LENGTH_NORM, CFG_DATA_W'(b));
        cfg_write(CFG_IDF_FLOOR, CFG_DATA_W'(fl));
        @(negedge i_clk);
    endtask

    function automatic t_pair mk(input logic [CNT_W-1:0] df, input logic [CNT_W-1:0] n,
                                 input logic [LEN_W-1:0] len, input logic [LEN_W-1:0] tf,
                                 input logic [AVG_W-1:0] avg, input bit fixed = 0,
                                 input logic [SCORE_W-1:0] rel = '0, input logic st = 1'b0);
        t_pair p;
        p.df = df; p.n = n; p.len = len; p.tf = tf; p.avg = avg;
        p.fixed = fixed; p.fix_rel = rel; p.fix_st = st;
        return p;
    endfunction

    // Random pair: mostly realistic corpus statistics, some raw noise
    function automatic t_pair rand_pair();
        t_pair p;
        int sel;
        sel = $urandom_range(0, 9);
        p.fixed = 0; p.fix_rel = '0; p.fix_st = 1'b0;
        if (sel < 3) begin
            p.df = $urandom; p.n = $urandom;
            p.len = LEN_W'($urandom); p.tf = LEN_W'($urandom); p.avg = $urandom;
        end else begin
            p.n = $urandom_range(1, (sel < 6) ? 1000 : 32'hFFFF_FFFE);
            p.df = (sel == 9) ? p.n + $urandom_range(0, 50) : $urandom_range(0, p.n);
            p.len = LEN_W'($urandom_range(0, (sel < 7) ? 2000 : 24'hFF_FFFF));
            p.tf = LEN_W'($urandom_range(0, (p.len < 100) ? 100 : p.len / 4));
            p.avg = (sel == 8) ? $urandom_range(0, 3) : $urandom_range(1, 32'h0007_D000);
        end
        return p;
    endfunction

    t_pair directed[$];
    int    per_phase;

    initial begin
        // Reset
        repeat (8) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // Directed rows at reset register values
        directed = '{
            mk(0, 0, 0, 0, 0, 1, 32'h0, 1'b1),
            mk('1, '1, '1, '1, 0, 1, 32'h0, 1'b1),
            mk('1, '1, '1, '1, '1),
            mk(0, 0, 0, 0, 1),
            mk(0, '1, 100, 10, 32'h0000_6400),
            mk('1, 0, 100, 10, 32'h0000_6400),
            mk(500, 100, 50, 5, 32'h0000_3200),
            mk(1, 1000000, '1, 3, 1),
            mk(1, 1000000, 0, '1, '1),
            mk(10, 1000, 200, 0, 32'h0000_C800),
            mk(3, 100, 1, 1, 32'h0000_0100),
            mk(32'hAAAA_AAAA, 32'h5555_5555, 24'hAA_AAAA, 24'h55_5555, 32'hA5A5_A5A5),
            mk(32'h5555_5555, 32'hAAAA_AAAA, 24'h55_5555, 24'hAA_AAAA, 32'h5A5A_5A5A)
        };
        foreach (directed[i]) send_pair(directed[i]);
        drain_pipe();

        // Zero k1, b and floor: zero tf gives a zero denominator
        set_regs(16'd0, 17'd0, 16'd0);
        directed = '{
            mk(10, 1000, 200, 0, 32'h0000_C800, 1, 32'h0, 1'b1),
            mk(500, 10, 200, 7, 32'h0000_C800),
            mk(10, 1000, 200, 7, 32'h0000_C800)
        };
        foreach (directed[i]) send_pair(directed[i]);
        drain_pipe();

        // Full length weight with empty document and zero tf: zero denominator
        set_regs(16'hFFFF, B_ONE, 16'hFFFF);
        directed = '{
            mk(10, 1000, 0, 0, 32'h0000_C800, 1, 32'h0, 1'b1),
            mk(1, '1, 24'hFF_FFFF, 24'hFF_FFFF, 32'h0000_0001),
            mk(1, '1, 24'h00_0001, 24'hFF_FFFF, '1)
        };
        foreach (directed[i]) send_pair(directed[i]);
        drain_pipe();

        // b above one saturates; unused register index is ignored
        set_regs(16'hFFFF, 17'h1_FFFF, 16'd0);
        cfg_write(t_cfg_idx'(3), 17'h1_5A5A);
        @(negedge i_clk);
        directed = '{
            mk(10, 1000, 300, 4, 32'h0000_C800),
            mk(2000, 1000, 300, 4, 32'h0000_C800)
        };
        foreach (directed[i]) send_pair(directed[i]);
        drain_pipe();

        // Random phases, each under its own register setting
        per_phase = 85;
        for (int ph = 0; ph < 10; ph++) begin
            case (ph)
                0: set_regs(K1_RESET, B_RESET, FLOOR_RESET);
                1: set_regs(16'd0, 17'd0, 16'd0);
                2: set_regs(16'hFFFF, B_ONE, 16'hFFFF);
                3: set_regs(16'hFFFF, 17'h1_FFFF, 16'd0);
                default: set_regs(K1_W'($urandom), B_W'($urandom_range(0, 17'h1_FFFF)),
                                  FLOOR_W'($urandom));
            endcase
            quiet = (ph == 4);
            if (ph == 5) hold_long = 1;
            for (int k = 0; k < per_phase; k++) send_pair(rand_pair());
            quiet = 0;
            drain_pipe();
        end

        if (mismatches == 0 && pending_scores.size() == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule
